// ----- rtl/sle_pkg.sv -----
// Shared types and constants for the sequential list engine.
// Depends on nothing; imported by the top level.
`default_nettype none

package sle_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam int ACTION_W = 4;
  localparam int POS_W    = 10;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 9;

  localparam int IN_FIELDS_W  = POS_W + VAL_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + VAL_W + INDEX_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INIT    = 4'd0,
    ACT_DESTROY = 4'd1,
    ACT_CLEAR   = 4'd2,
    ACT_EMPTY   = 4'd3,
    ACT_LENGTH  = 4'd4,
    ACT_GET     = 4'd5,
    ACT_LOCATE  = 4'd6,
    ACT_PRIOR   = 4'd7,
    ACT_NEXT    = 4'd8,
    ACT_INSERT  = 4'd9,
    ACT_DELETE  = 4'd10
  } act_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_ERR    = 2'd1,
    STAT_UNINIT = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_PLACE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/sle_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sequential_list_engine_unit.sv -----
// Top level of the sequential list engine: request decode, walk sequencer and result register.
// Depends on sle_pkg and sle_ram.
//
// Usage:
//   One request beat in on the s_ side (s_tuser carries the action, s_tdata the position
//   and value), one result beat out on the m_ side. The list lives in a single RAM of
//   CAPACITY words; length and the initialized flag live in flip-flops.
//   A request is taken only when the sequencer is idle (s_tready high); one request is
//   worked on at a time. The result register parts the two sides, so the next request
//   is taken while an earlier result still waits on m_tready.
//   Each request passes a decode step and ends in the done state. Init, destroy, clear,
//   empty, length and every request refused at decode go straight from decode to done;
//   get, locate, prior, next and delete walk the store in between, and insert walks and
//   then writes its value in a place step. The walk moves one list element per
//   cycle through the RAM's single read and single write port.
//   Reset leaves the list initialized and empty; RAM contents are not cleared, since
//   only entries below the length are ever read. No clearing pass is needed.
//   When the receiver stalls, the finished result holds in the output register and the
//   next result waits in its final state until the register frees up.

`default_nettype none

module sequential_list_engine_unit #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // position [9:0], value_in [41:10], zero pad above
  input  logic [sle_pkg::IN_DATA_W-1:0]  s_tdata,
  // action [3:0]
  input  logic [sle_pkg::ACTION_W-1:0]   s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status [1:0], data_out [33:2], index_out [42:34], is_empty [43], zero pad above
  output logic [sle_pkg::OUT_DATA_W-1:0] m_tdata
);

  import sle_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);          // length counter width
  localparam int AW = $clog2(CAPACITY);              // RAM address width
  localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1; // width for position compares

  // Sequencer and request registers
  state_t                  state, state_next;
  act_t                    act;
  logic [POS_W-1:0]        pos;
  logic signed [VAL_W-1:0] val;

  // List control state
  logic [LW-1:0]           len;
  logic                    ready;

  // Walk engine: cnt is the next read address, rem the reads left to issue,
  // rd_at the address of the word arriving from the RAM this cycle.
  logic [LW-1:0]           cnt;
  logic [LW-1:0]           rem;
  logic                    rd_vld;
  logic [LW-1:0]           rd_at;
  logic [VAL_W-1:0]        prev;
  logic                    pending;
  logic                    first;

  // Result under construction
  status_t                 res_status;
  logic signed [VAL_W-1:0] res_data;
  logic [INDEX_W-1:0]      res_index;

  // RAM port signals
  logic                    ram_rd_en;
  logic [AW-1:0]           ram_rd_addr;
  logic [VAL_W-1:0]        ram_rd_data;
  logic                    ram_wr_en;
  logic [AW-1:0]           ram_wr_addr;
  logic [VAL_W-1:0]        ram_wr_data;

  // Decode helpers
  logic [CW-1:0]           pos_ext, len_ext;
  logic                    in_rng, ins_rng, full;
  logic [LW-1:0]           pos_m1, shift_cnt, len_m1;
  logic [LW-1:0]           rd_at_inc, rd_at_dec;
  status_t                 dec_status;
  logic                    dec_walk;

  // Walk completion
  logic                    arr_match, walk_end, walk_fin, walk_place;
  status_t                 walk_status;

  logic                    out_free;
  logic                    is_empty;

  sle_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign is_empty = ready && (len == '0);

  // Position checks, all in a width that holds both length and position
  assign pos_ext   = CW'(pos);
  assign len_ext   = CW'(len);
  assign in_rng    = (pos_ext != '0) && (pos_ext <= len_ext);
  assign ins_rng   = (pos_ext != '0) && (pos_ext <= len_ext + CW'(1));
  assign full      = (len_ext >= CW'(CAPACITY));
  assign pos_m1    = LW'(pos_ext - CW'(1));
  assign shift_cnt = LW'(len_ext - pos_ext + CW'(1));
  assign len_m1    = len - LW'(1);
  assign rd_at_inc = rd_at + LW'(1);
  assign rd_at_dec = rd_at - LW'(1);

  // Decide the outcome of a request, or start a walk through the store
  always_comb begin
    dec_status = STAT_OK;
    dec_walk   = 1'b0;
    case (act)
      ACT_INIT: begin
        if (ready) dec_status = STAT_ERR;
      end
      ACT_DESTROY, ACT_CLEAR, ACT_EMPTY, ACT_LENGTH: begin
        if (!ready) dec_status = STAT_UNINIT;
      end
      ACT_GET, ACT_DELETE: begin
        if (!ready) dec_status = STAT_UNINIT;
        else if (!in_rng) dec_status = STAT_ERR;
        else dec_walk = 1'b1;
      end
      ACT_LOCATE, ACT_PRIOR, ACT_NEXT: begin
        if (!ready) dec_status = STAT_UNINIT;
        else dec_walk = 1'b1;
      end
      ACT_INSERT: begin
        if (!ready) dec_status = STAT_UNINIT;
        else if (!ins_rng) dec_status = STAT_ERR;
        else if (full) dec_status = STAT_FULL;
        else dec_walk = 1'b1;
      end
      default: begin
        dec_status = STAT_ERR;
      end
    endcase
  end

  // Judge each word as it comes back from the RAM
  assign arr_match = rd_vld && (ram_rd_data == val);
  assign walk_end  = (rem == '0) && !rd_vld;

  always_comb begin
    walk_fin    = 1'b0;
    walk_place  = 1'b0;
    walk_status = STAT_OK;
    case (act)
      ACT_GET: begin
        walk_fin = rd_vld;
      end
      ACT_LOCATE: begin
        if (arr_match) begin
          walk_fin = 1'b1;
        end else if (walk_end) begin
          walk_fin    = 1'b1;
          walk_status = STAT_ERR;
        end
      end
      ACT_PRIOR: begin
        // a match at the head has no predecessor: keep looking
        if (arr_match && (rd_at != '0)) begin
          walk_fin = 1'b1;
        end else if (walk_end) begin
          walk_fin    = 1'b1;
          walk_status = STAT_ERR;
        end
      end
      ACT_NEXT: begin
        if (pending && rd_vld) begin
          walk_fin = 1'b1;
        end else if (walk_end) begin
          walk_fin    = 1'b1;
          walk_status = STAT_ERR;
        end
      end
      ACT_INSERT: begin
        walk_place = walk_end;
      end
      ACT_DELETE: begin
        walk_fin = walk_end;
      end
      default: begin
        if (walk_end) begin
          walk_fin    = 1'b1;
          walk_status = STAT_ERR;
        end
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = dec_walk ? S_WALK : S_DONE;
      end
      S_WALK: begin
        if (walk_fin) state_next = S_DONE;
        else if (walk_place) state_next = S_PLACE;
      end
      S_PLACE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // RAM control: one read and one write per cycle at most
  always_comb begin
    ram_rd_en   = (state == S_WALK) && (rem != '0);
    ram_rd_addr = cnt[AW-1:0];
    ram_wr_en   = 1'b0;
    ram_wr_addr = rd_at_inc[AW-1:0];
    ram_wr_data = ram_rd_data;
    case (state)
      S_WALK: begin
        if (act == ACT_INSERT && rd_vld) begin
          // move the tail up one place, walking down from the end
          ram_wr_en   = 1'b1;
          ram_wr_addr = rd_at_inc[AW-1:0];
        end else if (act == ACT_DELETE && rd_vld && !first) begin
          // move the tail down one place, walking up from the hole
          ram_wr_en   = 1'b1;
          ram_wr_addr = rd_at_dec[AW-1:0];
        end
      end
      S_PLACE: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = pos_m1[AW-1:0];
        ram_wr_data = val;
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      len      <= '0;
      ready    <= 1'b1;
      m_tvalid <= 1'b0;
      rd_vld   <= 1'b0;
      rem      <= '0;
      pending  <= 1'b0;
      first    <= 1'b0;
    end else begin
      state <= state_next;
      // load a finished result, or drop the beat once it is taken
      if (state == S_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act       <= act_t'(s_tuser);
            pos       <= s_tdata[POS_W-1:0];
            val       <= s_tdata[POS_W +: VAL_W];
            res_data  <= '0;
            res_index <= '0;
          end
        end

        S_DECODE: begin
          res_status <= dec_status;
          rd_vld     <= 1'b0;
          pending    <= 1'b0;
          first      <= 1'b1;
          if (dec_status == STAT_OK) begin
            case (act)
              ACT_INIT: begin
                ready <= 1'b1;
                len   <= '0;
              end
              ACT_DESTROY: begin
                ready <= 1'b0;
                len   <= '0;
              end
              ACT_CLEAR: begin
                len <= '0;
              end
              ACT_LENGTH: begin
                res_index <= INDEX_W'(len);
              end
              ACT_GET: begin
                rem <= LW'(1);
                cnt <= pos_m1;
              end
              ACT_LOCATE, ACT_PRIOR, ACT_NEXT: begin
                rem <= len;
                cnt <= '0;
              end
              ACT_INSERT: begin
                rem <= shift_cnt;
                cnt <= len_m1;
              end
              ACT_DELETE: begin
                rem <= shift_cnt;
                cnt <= pos_m1;
              end
              default: begin
                rem <= '0;
              end
            endcase
          end
        end

        S_WALK: begin
          // issue side
          rd_vld <= (rem != '0);
          rd_at  <= cnt;
          if (rem != '0) begin
            rem <= rem - LW'(1);
            cnt <= (act == ACT_INSERT) ? cnt - LW'(1) : cnt + LW'(1);
          end
          // return side
          if (rd_vld) begin
            prev  <= ram_rd_data;
            first <= 1'b0;
          end
          if (act == ACT_DELETE && rd_vld && first) begin
            res_data <= ram_rd_data;
          end
          // a match before the last element arms the successor capture
          if (act == ACT_NEXT && arr_match && (rd_at_inc < len)) begin
            pending <= 1'b1;
          end
          if (walk_fin) begin
            res_status <= walk_status;
            if (walk_status == STAT_OK) begin
              case (act)
                ACT_GET, ACT_NEXT: res_data  <= ram_rd_data;
                ACT_PRIOR:         res_data  <= prev;
                ACT_LOCATE:        res_index <= INDEX_W'(rd_at_inc);
                ACT_DELETE:        len       <= len_m1;
                default:           res_data  <= res_data;
              endcase
            end
          end
        end

        S_PLACE: begin
          len <= len + LW'(1);
        end

        S_DONE: begin
          if (out_free) begin
            m_tdata  <= {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, is_empty, res_index,
                         res_data, res_status};
          end
        end

        default: begin
          rd_vld <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/sle_list_checker.sv -----
// Scoreboard for the sequential list engine: watches both stream channels,
// predicts each result from its own copy of the list and compares field by field.
// Depends on sle_pkg for widths, action and status codes.
`default_nettype none

module sle_list_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [sle_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [sle_pkg::ACTION_W-1:0]   s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [sle_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                             fails,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [VAL_W-1:0]   data;
    logic [INDEX_W-1:0] index;
    logic               is_empty;
  } list_result_t;

  logic [VAL_W-1:0] list_store [CAPACITY_DEF];
  int               list_len;
  logic             list_ready;
  list_result_t     result_q[$];
  int               fail_count;
  int               result_num;

  assign fails = fail_count;

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    fail_count++;
    $display("[%0t] result beat %0d: %s got 0x%0h, want 0x%0h",
             $realtime, result_num, what, got, want);
  endtask

  // Apply one request to the list copy and return the result it earns.
  function automatic list_result_t apply_request(input logic [ACTION_W-1:0] act,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [VAL_W-1:0] val);
    list_result_t r;
    int           p;
    int           j;
    r = '{status: STAT_OK, data: '0, index: '0, is_empty: 1'b0};
    p = int'(pos);
    if (act == ACT_INIT) begin
      if (list_ready) r.status = STAT_ERR;
      else begin
        list_ready = 1'b1;
        list_len   = 0;
      end
    end else if (act == ACT_DESTROY) begin
      if (!list_ready) r.status = STAT_UNINIT;
      else begin
        list_ready = 1'b0;
        list_len   = 0;
      end
    end else if (act > ACT_DELETE) begin
      r.status = STAT_ERR;
    end else if (!list_ready) begin
      r.status = STAT_UNINIT;
    end else begin
      case (act)
        ACT_CLEAR:  list_len = 0;
        ACT_LENGTH: r.index = INDEX_W'(list_len);
        ACT_GET: begin
          if (p < 1 || p > list_len) r.status = STAT_ERR;
          else r.data = list_store[p-1];
        end
        ACT_LOCATE: begin
          r.status = STAT_ERR;
          for (j = 0; j < list_len; j++) begin
            if (list_store[j] == val) begin
              r.index  = INDEX_W'(j + 1);
              r.status = STAT_OK;
              break;
            end
          end
        end
        ACT_PRIOR: begin
          r.status = STAT_ERR;
          for (j = 1; j < list_len; j++) begin
            if (list_store[j] == val) begin
              r.data   = list_store[j-1];
              r.status = STAT_OK;
              break;
            end
          end
        end
        ACT_NEXT: begin
          r.status = STAT_ERR;
          for (j = 0; j + 1 < list_len; j++) begin
            if (list_store[j] == val) begin
              r.data   = list_store[j+1];
              r.status = STAT_OK;
              break;
            end
          end
        end
        ACT_INSERT: begin
          if (p < 1 || p > list_len + 1) r.status = STAT_ERR;
          else if (list_len >= CAPACITY_DEF) r.status = STAT_FULL;
          else begin
            for (j = list_len; j > p - 1; j--) list_store[j] = list_store[j-1];
            list_store[p-1] = val;
            list_len++;
          end
        end
        ACT_DELETE: begin
          if (p < 1 || p > list_len) r.status = STAT_ERR;
          else begin
            r.data = list_store[p-1];
            for (j = p; j < list_len; j++) list_store[j-1] = list_store[j];
            list_len--;
          end
        end
        default: ;
      endcase
    end
    r.is_empty = list_ready && list_len == 0;
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      list_len   = 0;
      list_ready = 1'b1;
      result_q.delete();
    end else begin
      // Results first: no request can answer on the edge that takes it.
      if (m_tvalid && m_tready) begin
        result_num++;
        if (result_q.size() == 0) begin
          report_mismatch("result with no request waiting", m_tdata[VAL_W-1:0], '0);
        end else begin
          want = result_q.pop_front();
          if (m_tdata[STATUS_W-1:0] != want.status)
            report_mismatch("status", VAL_W'(m_tdata[STATUS_W-1:0]), VAL_W'(want.status));
          if (m_tdata[STATUS_W +: VAL_W] != want.data)
            report_mismatch("data_out", m_tdata[STATUS_W +: VAL_W], want.data);
          if (m_tdata[STATUS_W+VAL_W +: INDEX_W] != want.index)
            report_mismatch("index_out", VAL_W'(m_tdata[STATUS_W+VAL_W +: INDEX_W]),
                            VAL_W'(want.index));
          if (m_tdata[STATUS_W+VAL_W+INDEX_W] != want.is_empty)
            report_mismatch("is_empty", VAL_W'(m_tdata[STATUS_W+VAL_W+INDEX_W]),
                            VAL_W'(want.is_empty));
        end
      end
      if (s_tvalid && s_tready)
        result_q.push_back(apply_request(s_tuser, s_tdata[POS_W-1:0],
                                         s_tdata[POS_W +: VAL_W]));
    end
    pending = result_q.size();
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_sequential_list_engine_unit.sv -----
// Testbench top for the sequential list engine: clock, reset, request stimulus,
// result-side backpressure, watchdog and final verdict.
// Depends on sle_pkg, sequential_list_engine_unit and sle_list_checker.
`default_nettype none

module tb_sequential_list_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sle_pkg::*;

  localparam int ITEM_TOTAL   = 1850;
  localparam int FILL_EVERY   = 700;   // fill the list to capacity this often
  localparam int STALL_LIMIT  = 4000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 300;   // about one full-list walk

  // Codes past delete are unused; the block must answer them with an error.
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 4'd11;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 4'd15;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // position [9:0], value_in [41:10], zero pad above
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  // action [3:0]
  logic [ACTION_W-1:0]   s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // status [1:0], data_out [33:2], index_out [42:34], is_empty [43], zero pad above
  logic [OUT_DATA_W-1:0] m_tdata;

  int fails;
  int pending;

  sequential_list_engine_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sle_list_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .fails    (fails),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Rough view of the list, kept only to steer positions into range and to
  // know when the list is full; the checker does the real prediction.
  int               shadow_len   = 0;
  logic             shadow_ready = 1'b1;
  int               sent         = 0;
  logic             send_nogap   = 1'b0;
  logic [VAL_W-1:0] value_pool [8];

  // Draw a value: mostly from a small pool so that searches hit and
  // duplicates appear, otherwise any 32-bit pattern.
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // Draw a position: mostly inside 1..span, otherwise just outside or anywhere.
  function automatic logic [POS_W-1:0] pick_pos(input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85 && span >= 1) return POS_W'($urandom_range(1, span));
    if (r < 90) return '0;
    if (r < 95) return POS_W'(span + 1);
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  // Offer one request beat after a random gap and hold it until taken.
  task automatic send(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                      input logic [VAL_W-1:0] val);
    int gap;
    int p;
    // Switch between gap-free stretches and gappy ones every 64 beats.
    if (sent % 64 == 0) send_nogap = ($urandom_range(0, 3) == 0);
    gap = send_nogap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {{(IN_DATA_W - POS_W - VAL_W){1'b0}}, val, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    p = int'(pos);
    case (act)
      ACT_INIT: if (!shadow_ready) begin
        shadow_ready = 1'b1;
        shadow_len   = 0;
      end
      ACT_DESTROY: if (shadow_ready) begin
        shadow_ready = 1'b0;
        shadow_len   = 0;
      end
      ACT_CLEAR: if (shadow_ready) shadow_len = 0;
      ACT_INSERT:
        if (shadow_ready && p >= 1 && p <= shadow_len + 1 && shadow_len < CAPACITY_DEF)
          shadow_len++;
      ACT_DELETE:
        if (shadow_ready && p >= 1 && p <= shadow_len) shadow_len--;
      default: ;
    endcase
  endtask

  // One random request, steered toward a target length.
  task automatic random_request(input int len_goal);
    int                  r;
    logic                grow;
    logic [ACTION_W-1:0] act;
    logic [POS_W-1:0]    pos;
    logic [VAL_W-1:0]    val;
    r   = $urandom_range(0, 99);
    pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
    val = pick_value();
    if (!shadow_ready && r < 70) act = ACT_INIT;
    else if (r < 2)  act = ACT_DESTROY;
    else if (r < 4)  act = ACT_CLEAR;
    else if (r < 7)  act = ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    else if (r < 9)  act = ACT_INIT;
    else if (r < 12) act = ACT_EMPTY;
    else if (r < 15) act = ACT_LENGTH;
    else if (r < 25) begin
      act = ACT_GET;
      pos = pick_pos(shadow_len);
    end
    else if (r < 35) act = ACT_LOCATE;
    else if (r < 42) act = ACT_PRIOR;
    else if (r < 49) act = ACT_NEXT;
    else begin
      grow = (shadow_len < len_goal) ? ($urandom_range(0, 99) < 75)
                                     : ($urandom_range(0, 99) < 25);
      if (grow) begin
        act = ACT_INSERT;
        pos = pick_pos(shadow_len + 1);
      end else begin
        act = ACT_DELETE;
        pos = pick_pos(shadow_len);
      end
    end
    send(act, pos, val);
  endtask

  // Result side: random gaps per beat, gap-free stretches, and two long
  // hold-offs so the result register backs up and the input stalls.
  initial begin
    int got;
    int gap;
    logic nogap;
    got   = 0;
    nogap = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (got % 64 == 0) nogap = ($urandom_range(0, 3) == 0);
      gap = nogap ? 0 : $urandom_range(0, 3);
      if (got == 300 || got == 1100) gap = HOLD_CYCLES;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got++;
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int len_goal;
    int goal_until;
    int next_fill;
    int r;
    int i;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (i = 4; i < 8; i++) value_pool[i] = $urandom();

    // Hold reset, then release it once.
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: fresh list, range edges, searches at the list ends,
    // unused codes, and length, destroy and init on a destroyed list.
    send(ACT_EMPTY,   '0, '0);
    send(ACT_INIT,    '0, '0);             // already initialized
    send(ACT_GET,     10'd1, '0);          // empty list
    send(ACT_INSERT,  10'd1, 32'h8000_0000);
    send(ACT_INSERT,  10'd2, 32'h7fff_ffff);
    send(ACT_INSERT,  10'd1, 32'h0000_0000);
    send(ACT_INSERT,  10'd0, 32'h1234_5678); // position zero
    send(ACT_INSERT,  10'd1023, 32'h1234_5678);
    send(ACT_GET,     10'd3, '0);
    send(ACT_GET,     10'd1023, '0);
    send(ACT_LENGTH,  '0, '0);
    send(ACT_LOCATE,  '0, 32'h7fff_ffff);
    send(ACT_LOCATE,  '0, 32'hffff_ffff);  // not found
    send(ACT_PRIOR,   '0, 32'h0000_0000);  // first element, no later match
    send(ACT_NEXT,    '0, 32'h7fff_ffff);  // last element
    send(ACT_PRIOR,   '0, 32'h8000_0000);
    send(ACT_NEXT,    '0, 32'h0000_0000);
    send(ACT_DELETE,  10'd0, '0);
    send(ACT_DELETE,  10'd2, '0);
    send(ACT_SPARE_LO, 10'h3ff, 32'hffff_ffff);
    send(ACT_SPARE_HI, '0, '0);
    send(ACT_CLEAR,   '0, '0);
    send(ACT_DESTROY, '0, '0);
    send(ACT_LENGTH,  '0, '0);             // not initialized
    send(ACT_DESTROY, '0, '0);             // not initialized
    send(ACT_INIT,    '0, '0);

    // Random part: wander around a target length that is redrawn now and
    // then, and twice fill the list to capacity to reach the full case and
    // the longest walks.
    len_goal   = 8;
    goal_until = sent + 100;
    next_fill  = FILL_EVERY;
    while (sent < ITEM_TOTAL) begin
      if (sent >= next_fill) begin
        if (!shadow_ready) send(ACT_INIT, '0, '0);
        while (shadow_len < CAPACITY_DEF)
          send(ACT_INSERT, POS_W'($urandom_range(1, shadow_len + 1)), pick_value());
        next_fill += FILL_EVERY;
        len_goal   = CAPACITY_DEF;
        goal_until = sent + 30;
      end else if (sent >= goal_until) begin
        r = $urandom_range(0, 99);
        if (r < 80)      len_goal = $urandom_range(0, 16);
        else if (r < 95) len_goal = $urandom_range(0, 64);
        else             len_goal = $urandom_range(0, CAPACITY_DEF);
        goal_until = sent + 100;
      end
      random_request(len_goal);
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every result, then let the block settle.
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
